/* sv/shph_pkg.sv */
// ----------------------------------------------------------------------------
// shph_pkg
// Shared constants, link type and the modular Horner step for the shingle
// polynomial hasher.
// ----------------------------------------------------------------------------
package shph_pkg;

    // hash arithmetic
    localparam int unsigned HASH_W        = 30;
    localparam logic [31:0] HASH_PRIME    = 32'd1009010791;
    localparam logic [31:0] HASH_PRIME_X2 = 32'd2018021582;
    localparam logic [34:0] HASH_BASE     = 35'd29;
    localparam logic [31:0] DIGIT_OFFSET  = 32'd96;
    // 2^30 mod prime, used to fold the bits above bit 29
    localparam logic [31:0] FOLD_K        = 32'd64731033;

    // configuration defaults
    localparam int unsigned SHPH_MAX_WINDOW = 8;
    localparam int unsigned WIN_LEN_W       = 4;
    localparam logic [3:0]  WIN_LEN_RESET   = 4'd5;

    // partial hash handed from one cell to the next
    typedef struct packed {
        logic              act;
        logic [HASH_W-1:0] hash;
    } t_link;

    // one Horner step: (h * 29 + (b - 96)) mod prime, h already reduced
    function automatic logic [HASH_W-1:0] hash_step(
        input logic [HASH_W-1:0] h,
        input logic [7:0]        b
    );
        logic [34:0] v;
        logic [31:0] f;
        logic [31:0] r;
        v = 35'(h) * HASH_BASE + 35'(b) + 35'(HASH_PRIME - DIGIT_OFFSET);
        // fold high bits back in: result stays below three times the prime
        f = 32'(v[34:30]) * FOLD_K + 32'(v[29:0]);
        if (f >= HASH_PRIME_X2) begin
            r = f - HASH_PRIME_X2;
        end else if (f >= HASH_PRIME) begin
            r = f - HASH_PRIME;
        end else begin
            r = f;
        end
        return r[HASH_W-1:0];
    endfunction

endpackage

/* sv/shph_if.sv */
// ----------------------------------------------------------------------------
// shph_if
// Valid/ready channels of the shingle polynomial hasher: byte items in,
// hash items out, and the window length write port.
// ----------------------------------------------------------------------------

// byte item channel
interface shph_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       doc_start;
    modport source (output valid, output char_byte, output doc_start, input ready);
    modport sink   (input valid, input char_byte, input doc_start, output ready);
endinterface

// hash item channel
interface shph_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] shingle_hash;
    modport source (output valid, output shingle_hash, input ready);
    modport sink   (input valid, input shingle_hash, output ready);
endinterface

// window length write channel
interface shph_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] window_len;
    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

/* sv/shph_cell.sv */
// ----------------------------------------------------------------------------
// shph_cell
// One cell of the window chain: holds one byte of the window and, when the
// hash token reaches it, folds its byte into the partial hash.
// ----------------------------------------------------------------------------
module shph_cell
    import shph_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  t_link      i_link,
    output logic [7:0] o_byte,
    output t_link      o_link
);

    logic [7:0]        r_byte;
    logic              r_act;
    logic [HASH_W-1:0] r_hash;
    logic              w_fire;
    logic [HASH_W-1:0] w_hash_in;

    // token arrives from the older neighbor, or starts here with an empty hash
    assign w_fire    = i_start | i_link.act;
    assign w_hash_in = i_start ? '0 : i_link.hash;

    // window byte, moves one cell older on each accepted item
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // token flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= w_fire;
        end
    end

    // partial hash
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hash <= hash_step(w_hash_in, r_byte);
        end
    end

    assign o_byte      = r_byte;
    assign o_link.act  = r_act;
    assign o_link.hash = r_hash;

endmodule

/* sv/shingle_polynomial_hasher.sv */
// Items without a result (window not yet full) are taken one per cycle while not busy.
// An item that yields a hash sets the launch register; the hash token then walks the cell
// chain one cell per cycle toward cell 0 and waits there until the output register is free.
// The next item is taken only once its hash is loaded into the output register.
// Synchronous active-low reset: window length 5, empty window, no items held.
// ----------------------------------------------------------------------------
// shingle_polynomial_hasher
// Rolling polynomial hash (base 29, modulo 1009010791) over the last
// window_len bytes of each document, oldest byte first.
// ----------------------------------------------------------------------------
module shingle_polynomial_hasher
    import shph_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = SHPH_MAX_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shph_in_if.sink     i_item,
    shph_cfg_if.sink    i_cfg,
    shph_out_if.source  o_result
);

    localparam int unsigned LW = $clog2(MAX_WINDOW + 1);

    logic [WIN_LEN_W-1:0] r_window_len;
    logic [LW-1:0]        r_fill;
    logic [LW-1:0]        n_fill;
    logic                 r_busy;
    logic                 r_launch;
    logic                 r_pend;
    logic                 r_out_valid;
    logic [HASH_W-1:0]    r_out_hash;

    logic [LW-1:0]        w_len;
    logic                 w_accept;
    logic                 w_emit;
    logic                 w_avail;
    logic                 w_out_free;
    logic                 w_load;
    logic [7:0]           w_byte [MAX_WINDOW+1];
    t_link                w_link [MAX_WINDOW+1];
    logic [MAX_WINDOW-1:0] w_act;

    // configuration port always takes writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WIN_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_window_len <= i_cfg.window_len;
        end
    end

    // effective window length, clamped to 1..MAX_WINDOW
    always_comb begin
        if (r_window_len == '0) begin
            w_len = LW'(1);
        end else if (32'(r_window_len) > 32'(MAX_WINDOW)) begin
            w_len = LW'(MAX_WINDOW);
        end else begin
            w_len = LW'(r_window_len);
        end
    end

    // document fill count, saturating at the chain length
    always_comb begin
        if (i_item.doc_start) begin
            n_fill = LW'(1);
        end else if (r_fill == LW'(MAX_WINDOW)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + LW'(1);
        end
    end

    assign i_item.ready = !r_busy;
    assign w_accept     = i_item.valid && !r_busy;
    assign w_emit       = n_fill >= w_len;

    // result hand-off from the newest cell to the output register
    assign w_avail    = w_link[0].act || r_pend;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_load     = w_avail && w_out_free;

    // control: busy from an emitting accept until its hash is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_launch    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill <= n_fill;
            end
            r_launch <= w_accept && w_emit;
            if (w_accept && w_emit) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            r_pend <= w_avail && !w_out_free;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_hash <= w_link[0].hash;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.shingle_hash = r_out_hash;

    // cell chain: bytes move toward older cells, the hash token toward cell 0
    assign w_byte[0]          = i_item.char_byte;
    assign w_link[MAX_WINDOW] = '0;

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        shph_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_byte  (w_byte[k]),
            .i_start (r_launch && (LW'(k + 1) == w_len)),
            .i_link  (w_link[k+1]),
            .o_byte  (w_byte[k+1]),
            .o_link  (w_link[k])
        );
        assign w_act[k] = w_link[k].act;
    end

    // the hash token is in at most one cell
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_act))
        else $error("more than one cell holds the hash token");

    // a launch belongs to an item still in flight
    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |-> r_busy)
        else $error("hash launched with no item in flight");

    // the token leaves the chain only while busy and with no result parked
    a_token_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[0].act |-> (r_busy && !r_pend))
        else $error("hash token finished out of turn");

    // a parked result keeps the input closed
    a_pend_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_item.ready)
        else $error("input open while a result is parked");

    // the delivered hash is a reduced residue
    a_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (32'(r_out_hash) < HASH_PRIME))
        else $error("output hash not reduced");

endmodule
